// File: hw/rtl/fet_pkg.sv
package fet_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned SEC_W         = 32;
  localparam int unsigned ENT_W         = 2 * SEC_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SEC_W-1:0] sec_t;

  localparam idx_t IDX_MAX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_PREP,
    S_SCAN_RD,
    S_SCAN_EV,
    S_RESOLVE,
    S_MV_RD,
    S_MV_WR,
    S_DONE
  } state_e;

  // request payload as seen by the sequencer
  typedef struct packed {
    logic [1:0] action;
    sec_t       sector;
    sec_t       count;
    sec_t       last_sector;
  } req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic       done;
    sec_t       start_sector;
    logic [1:0] status;
  } res_t;

  // extent table port; entry is {first, last}
  typedef struct packed {
    logic             we;
    idx_t             waddr;
    logic [ENT_W-1:0] wdata;
    logic             re;
    idx_t             raddr;
  } ram_req_t;

endpackage

// File: hw/rtl/fet_req_if.sv
interface fet_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] sector;
  logic [31:0] count;
  logic [31:0] last_sector;

  modport source (output valid, action, sector, count, last_sector, input ready);
  modport sink   (input valid, action, sector, count, last_sector, output ready);
endinterface

// File: hw/rtl/fet_rsp_if.sv
interface fet_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_sector;
  logic [1:0]  status;

  modport source (output valid, start_sector, status, input ready);
  modport sink   (input valid, start_sector, status, output ready);
endinterface

// File: hw/rtl/fet_ram.sv
module fet_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fet_ctrl.sv
module fet_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  fet_pkg::req_t                req_i,
  output logic                         req_ready_o,
  input  logic                         out_free_i,
  output fet_pkg::res_t                res_o,
  output fet_pkg::ram_req_t            ram_o,
  input  logic [fet_pkg::ENT_W-1:0]    ram_rdata_i
);

  fet_pkg::state_e  state_q, state_d;
  fet_pkg::action_e act_q, act_d;
  fet_pkg::sec_t    sector_q, sector_d;
  fet_pkg::sec_t    cnt_m1_q, cnt_m1_d;
  logic [fet_pkg::SEC_W:0] after_q, after_d;
  fet_pkg::sec_t    end_q, end_d;
  fet_pkg::sec_t    sec_m1_q, sec_m1_d;
  fet_pkg::idx_t    idx_q, idx_d;
  logic             pre_f_q, pre_f_d, post_f_q, post_f_d;
  fet_pkg::idx_t    pre_idx_q, pre_idx_d, post_idx_q, post_idx_d;
  fet_pkg::sec_t    pre_first_q, pre_first_d, pre_last_q, pre_last_d;
  fet_pkg::sec_t    post_first_q, post_first_d, post_last_q, post_last_d;
  logic             k_f_q, k_f_d, e0_f_q, e0_f_d, eb_f_q, eb_f_d, ea_f_q, ea_f_d;
  fet_pkg::idx_t    k_q, k_d, e0_q, e0_d, eb_q, eb_d, ea_q, ea_d;
  fet_pkg::idx_t    cur_q, cur_d, tgt_q, tgt_d;
  logic             dir_q, dir_d;
  fet_pkg::sec_t    start_q, start_d;
  fet_pkg::status_e status_q, status_d;
  logic [fet_pkg::TABLE_ENTRIES-1:0] valid_q, valid_d;

  fet_pkg::sec_t           e_first, e_last;
  logic                    nonempty;
  logic [fet_pkg::SEC_W:0] sum_m1;
  fet_pkg::idx_t           src;

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fet_pkg::S_IDLE;
      valid_q  <= '0;
      pre_f_q  <= 1'b0;
      post_f_q <= 1'b0;
      k_f_q    <= 1'b0;
      e0_f_q   <= 1'b0;
      eb_f_q   <= 1'b0;
      ea_f_q   <= 1'b0;
      idx_q    <= '0;
      cur_q    <= '0;
      tgt_q    <= '0;
      dir_q    <= 1'b0;
      act_q    <= fet_pkg::ACT_NOP;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      pre_f_q  <= pre_f_d;
      post_f_q <= post_f_d;
      k_f_q    <= k_f_d;
      e0_f_q   <= e0_f_d;
      eb_f_q   <= eb_f_d;
      ea_f_q   <= ea_f_d;
      idx_q    <= idx_d;
      cur_q    <= cur_d;
      tgt_q    <= tgt_d;
      dir_q    <= dir_d;
      act_q    <= act_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sector_q     <= sector_d;
    cnt_m1_q     <= cnt_m1_d;
    after_q      <= after_d;
    end_q        <= end_d;
    sec_m1_q     <= sec_m1_d;
    pre_idx_q    <= pre_idx_d;
    post_idx_q   <= post_idx_d;
    pre_first_q  <= pre_first_d;
    pre_last_q   <= pre_last_d;
    post_first_q <= post_first_d;
    post_last_q  <= post_last_d;
    k_q          <= k_d;
    e0_q         <= e0_d;
    eb_q         <= eb_d;
    ea_q         <= ea_d;
    start_q      <= start_d;
    status_q     <= status_d;
  end

  // entry just read; an entry never written reads as empty
  assign e_first  = valid_q[idx_q] ? ram_rdata_i[fet_pkg::ENT_W-1:fet_pkg::SEC_W] : '0;
  assign e_last   = valid_q[idx_q] ? ram_rdata_i[fet_pkg::SEC_W-1:0] : '0;
  assign nonempty = (e_first != '0);
  // shared adder: first + count - 1
  assign sum_m1   = {1'b0, e_first} + {1'b0, cnt_m1_q};
  // source of the next move
  assign src      = dir_q ? (cur_q + 1'b1) : (cur_q - 1'b1);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    sector_d     = sector_q;
    cnt_m1_d     = cnt_m1_q;
    after_d      = after_q;
    end_d        = end_q;
    sec_m1_d     = sec_m1_q;
    idx_d        = idx_q;
    pre_f_d      = pre_f_q;
    post_f_d     = post_f_q;
    pre_idx_d    = pre_idx_q;
    post_idx_d   = post_idx_q;
    pre_first_d  = pre_first_q;
    pre_last_d   = pre_last_q;
    post_first_d = post_first_q;
    post_last_d  = post_last_q;
    k_f_d        = k_f_q;
    e0_f_d       = e0_f_q;
    eb_f_d       = eb_f_q;
    ea_f_d       = ea_f_q;
    k_d          = k_q;
    e0_d         = e0_q;
    eb_d         = eb_q;
    ea_d         = ea_q;
    cur_d        = cur_q;
    tgt_d        = tgt_q;
    dir_d        = dir_q;
    start_d      = start_q;
    status_d     = status_q;
    valid_d      = valid_q;
    ram_o        = '0;
    res_o        = '0;
    req_ready_o  = 1'b0;

    unique case (state_q)
      fet_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          act_d    = fet_pkg::action_e'(req_i.action);
          sector_d = req_i.sector;
          cnt_m1_d = req_i.count - 1'b1;
          after_d  = {1'b0, req_i.sector} + {1'b0, req_i.count};
          end_d    = req_i.last_sector;
          start_d  = '0;
          status_d = fet_pkg::ST_OK;
          priority if (fet_pkg::action_e'(req_i.action) == fet_pkg::ACT_INIT) begin
            state_d = fet_pkg::S_INIT;
          end else if (fet_pkg::action_e'(req_i.action) == fet_pkg::ACT_NOP) begin
            state_d = fet_pkg::S_DONE;
          end else if (req_i.count == '0) begin
            status_d = fet_pkg::ST_ZERO;
            state_d  = fet_pkg::S_DONE;
          end else begin
            state_d = fet_pkg::S_PREP;
          end
        end
      end

      // drop every entry, store the disk extent in entry 0
      fet_pkg::S_INIT: begin
        valid_d     = '0;
        valid_d[0]  = 1'b1;
        ram_o.we    = 1'b1;
        ram_o.waddr = '0;
        ram_o.wdata = {sector_q, end_q};
        state_d     = fet_pkg::S_DONE;
      end

      // derive run end and clear scan trackers; reject a free at sector 0 or past the end
      fet_pkg::S_PREP: begin
        end_d    = after_q[fet_pkg::SEC_W-1:0] - 1'b1;
        sec_m1_d = sector_q - 1'b1;
        idx_d    = '0;
        pre_f_d  = 1'b0;
        post_f_d = 1'b0;
        k_f_d    = 1'b0;
        e0_f_d   = 1'b0;
        eb_f_d   = 1'b0;
        ea_f_d   = 1'b0;
        if (act_q == fet_pkg::ACT_FREE && (sector_q == '0 ||
            (after_q[fet_pkg::SEC_W] && after_q[fet_pkg::SEC_W-1:0] != '0))) begin
          status_d = fet_pkg::ST_NOFIT;
          state_d  = fet_pkg::S_DONE;
        end else begin
          state_d = fet_pkg::S_SCAN_RD;
        end
      end

      fet_pkg::S_SCAN_RD: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = idx_q;
        state_d     = fet_pkg::S_SCAN_EV;
      end

      fet_pkg::S_SCAN_EV: begin
        if (act_q == fet_pkg::ACT_ALLOC) begin
          // first fit
          if (nonempty && sum_m1 <= {1'b0, e_last}) begin
            start_d = e_first;
            if (sum_m1 == {1'b0, e_last}) begin
              valid_d[idx_q] = 1'b0;
            end else begin
              ram_o.we    = 1'b1;
              ram_o.waddr = idx_q;
              ram_o.wdata = {sum_m1[fet_pkg::SEC_W-1:0] + 1'b1, e_last};
            end
            state_d = fet_pkg::S_DONE;
          end else if (idx_q == fet_pkg::IDX_MAX) begin
            status_d = fet_pkg::ST_NOFIT;
            state_d  = fet_pkg::S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = fet_pkg::S_SCAN_RD;
          end
        end else begin
          // neighbors of the freed run
          if (nonempty) begin
            if (e_last == sec_m1_q) begin
              if (!pre_f_q) begin
                pre_f_d     = 1'b1;
                pre_idx_d   = idx_q;
                pre_first_d = e_first;
                pre_last_d  = e_last;
              end
            end else if ({1'b0, e_first} == after_q) begin
              if (!post_f_q) begin
                post_f_d     = 1'b1;
                post_idx_d   = idx_q;
                post_first_d = e_first;
                post_last_d  = e_last;
              end
            end
          end
          // insertion point and free slots around it
          if (!k_f_q) begin
            if (nonempty && sum_m1 < {1'b0, e_last}) begin
              k_f_d = 1'b1;
              k_d   = idx_q;
            end else if (!nonempty) begin
              eb_f_d = 1'b1;
              eb_d   = idx_q;
            end
          end else if (!ea_f_q && !nonempty) begin
            ea_f_d = 1'b1;
            ea_d   = idx_q;
          end
          if (!nonempty && !e0_f_q) begin
            e0_f_d = 1'b1;
            e0_d   = idx_q;
          end
          if (idx_q == fet_pkg::IDX_MAX) begin
            state_d = fet_pkg::S_RESOLVE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = fet_pkg::S_SCAN_RD;
          end
        end
      end

      // merge, or plan the insertion
      fet_pkg::S_RESOLVE: begin
        state_d = fet_pkg::S_DONE;
        priority if (pre_f_q && post_f_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = (pre_idx_q < post_idx_q) ? pre_idx_q : post_idx_q;
          ram_o.wdata = {(pre_first_q < post_first_q) ? pre_first_q : post_first_q,
                         (pre_last_q > post_last_q) ? pre_last_q : post_last_q};
          valid_d[(pre_idx_q < post_idx_q) ? post_idx_q : pre_idx_q] = 1'b0;
        end else if (pre_f_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = pre_idx_q;
          ram_o.wdata = {pre_first_q, end_q};
        end else if (post_f_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = post_idx_q;
          ram_o.wdata = {sector_q, post_last_q};
        end else if (!k_f_q) begin
          if (e0_f_q) begin
            ram_o.we      = 1'b1;
            ram_o.waddr   = e0_q;
            ram_o.wdata   = {sector_q, end_q};
            valid_d[e0_q] = 1'b1;
          end else begin
            status_d = fet_pkg::ST_FULL;
          end
        end else if (ea_f_q) begin
          cur_d   = ea_q;
          tgt_d   = k_q;
          dir_d   = 1'b0;
          state_d = fet_pkg::S_MV_RD;
        end else if (eb_f_q) begin
          cur_d   = eb_q;
          tgt_d   = k_q - 1'b1;
          dir_d   = 1'b1;
          state_d = fet_pkg::S_MV_RD;
        end else begin
          status_d = fet_pkg::ST_FULL;
        end
      end

      // move one entry toward the free slot, or place the run
      fet_pkg::S_MV_RD: begin
        if (cur_q == tgt_q) begin
          ram_o.we       = 1'b1;
          ram_o.waddr    = tgt_q;
          ram_o.wdata    = {sector_q, end_q};
          valid_d[tgt_q] = 1'b1;
          state_d        = fet_pkg::S_DONE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = src;
          state_d     = fet_pkg::S_MV_WR;
        end
      end

      fet_pkg::S_MV_WR: begin
        ram_o.we       = 1'b1;
        ram_o.waddr    = cur_q;
        ram_o.wdata    = ram_rdata_i;
        valid_d[cur_q] = 1'b1;
        cur_d          = src;
        state_d        = fet_pkg::S_MV_RD;
      end

      fet_pkg::S_DONE: begin
        if (out_free_i) begin
          res_o.done         = 1'b1;
          res_o.start_sector = start_q;
          res_o.status       = status_q;
          state_d            = fet_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fet_pkg::S_IDLE;
      end
    endcase
  end

  // one read and one write port: never read and write in one cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_o.we && ram_o.re))
    else $error("table read and write in the same cycle");

  // a taken request always leaves idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q != fet_pkg::S_IDLE))
    else $error("request taken but sequencer stayed idle");

  // both merge neighbors are distinct entries
  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fet_pkg::S_RESOLVE && pre_f_q && post_f_q) |-> (pre_idx_q != post_idx_q))
    else $error("merge neighbors share an entry");

  // a move never targets the final slot
  a_move_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fet_pkg::S_MV_WR) |-> (cur_q != tgt_q))
    else $error("entry move past insertion slot");

endmodule

// File: hw/rtl/free_extent_table_allocator.sv
// Flow: init writes entry 0; allocate scans up to the first fit; free scans every entry,
// then merges with a neighbor or moves entries toward a free slot to place the run.
// Rate: one request at a time; the table sits in one RAM with a single read port,
// and each entry visit takes a read and an evaluate state, each move a read and a write.
// Reset: the per-entry valid flags clear at once, so the table reads empty right away.
module free_extent_table_allocator (
  input logic     clk_i,
  input logic     rst_ni,
  fet_req_if.sink   req_i,
  fet_rsp_if.source rsp_o
);

  fet_pkg::req_t     req;
  fet_pkg::res_t     res;
  fet_pkg::ram_req_t ram;
  logic [fet_pkg::ENT_W-1:0] ram_rdata;
  logic          out_free;
  logic          out_valid_q;
  fet_pkg::sec_t out_start_q;
  logic [1:0]    out_status_q;

  assign req.action      = req_i.action;
  assign req.sector      = req_i.sector;
  assign req.count       = req_i.count;
  assign req.last_sector = req_i.last_sector;

  fet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (req),
    .req_ready_o (req_i.ready),
    .out_free_i  (out_free),
    .res_o       (res),
    .ram_o       (ram),
    .ram_rdata_i (ram_rdata)
  );

  fet_ram #(
    .WIDTH (fet_pkg::ENT_W),
    .DEPTH (fet_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram.we),
    .waddr_i (ram.waddr),
    .wdata_i (ram.wdata),
    .re_i    (ram.re),
    .raddr_i (ram.raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      out_start_q  <= res.start_sector;
      out_status_q <= res.status;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.start_sector = out_start_q;
  assign rsp_o.status       = out_status_q;

endmodule

// File: tb/tb_fet_ifs.sv
// Interfaces are part of the RTL (fet_req_if, fet_rsp_if); nothing extra needed here.
package tb_fet_cfg_pkg;
  localparam int unsigned GAP_MAX = 16;
endpackage

// File: tb/tb_free_extent_table_allocator.sv
module tb_free_extent_table_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import fet_pkg::*;

  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM   = 1150;

  logic clk_i;
  logic rst_ni;

  fet_req_if req_if ();
  fet_rsp_if rsp_if ();

  free_extent_table_allocator u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the extent table
  sec_t ext_first [TABLE_ENTRIES];
  sec_t ext_last  [TABLE_ENTRIES];

  typedef struct packed {
    sec_t    start_sector;
    status_e status;
  } alloc_result_t;

  alloc_result_t pending_results[$];
  int unsigned   n_errors;
  int unsigned   idle_cycles;
  bit            stim_done;

  function automatic sec_t span_of(int unsigned i);
    return (ext_last[i] >= ext_first[i]) ? ext_last[i] - ext_first[i] : '0;
  endfunction

  function automatic void clear_extents();
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      ext_first[i] = '0;
      ext_last[i]  = '0;
    end
  endfunction

  function automatic status_e insert_run(sec_t sector, sec_t endv, sec_t count);
    int unsigned k;
    int unsigned g;
    k = TABLE_ENTRIES;
    g = TABLE_ENTRIES;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      if (ext_first[i] != 0 && span_of(i) > count - 32'd1) begin
        k = i;
        break;
      end
    end
    // no larger entry: take the first hole
    if (k == TABLE_ENTRIES) begin
      for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
        if (ext_first[i] == 0) begin
          g = i;
          break;
        end
      end
      if (g == TABLE_ENTRIES) return ST_FULL;
      ext_first[g] = sector;
      ext_last[g]  = endv;
      return ST_OK;
    end
    for (int unsigned i = k + 1; i < TABLE_ENTRIES; i++) begin
      if (ext_first[i] == 0) begin
        g = i;
        break;
      end
    end
    // shift down toward the hole after k
    if (g != TABLE_ENTRIES) begin
      for (int unsigned i = g; i > k; i--) begin
        ext_first[i] = ext_first[i-1];
        ext_last[i]  = ext_last[i-1];
      end
      ext_first[k] = sector;
      ext_last[k]  = endv;
      return ST_OK;
    end
    // otherwise shift up from the hole before k
    for (int unsigned i = k; i > 0; i--) begin
      if (ext_first[i-1] == 0) begin
        g = i - 1;
        break;
      end
    end
    if (g == TABLE_ENTRIES) return ST_FULL;
    for (int unsigned i = g; i + 1 < k; i++) begin
      ext_first[i] = ext_first[i+1];
      ext_last[i]  = ext_last[i+1];
    end
    ext_first[k-1] = sector;
    ext_last[k-1]  = endv;
    return ST_OK;
  endfunction

  function automatic status_e free_run(sec_t sector, sec_t count);
    logic [32:0] after;
    int unsigned pre;
    int unsigned post;
    int unsigned keep;
    int unsigned gone;
    sec_t        lo;
    sec_t        hi;
    after = {1'b0, sector} + {1'b0, count};
    pre   = TABLE_ENTRIES;
    post  = TABLE_ENTRIES;
    if (sector == 0 || after - 33'd1 > 33'hFFFF_FFFF) return ST_NOFIT;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      if (ext_first[i] == 0) continue;
      if ({1'b0, ext_last[i]} + 33'd1 == {1'b0, sector}) begin
        if (pre == TABLE_ENTRIES) pre = i;
      end else if ({1'b0, ext_first[i]} == after) begin
        if (post == TABLE_ENTRIES) post = i;
      end
    end
    if (pre != TABLE_ENTRIES && post != TABLE_ENTRIES) begin
      keep = (pre < post) ? pre : post;
      gone = (pre < post) ? post : pre;
      lo = (ext_first[pre] < ext_first[post]) ? ext_first[pre] : ext_first[post];
      hi = (ext_last[pre] > ext_last[post]) ? ext_last[pre] : ext_last[post];
      ext_first[keep] = lo;
      ext_last[keep]  = hi;
      ext_first[gone] = '0;
      ext_last[gone]  = '0;
      return ST_OK;
    end
    if (pre != TABLE_ENTRIES) begin
      ext_last[pre] = sec_t'(after - 33'd1);
      return ST_OK;
    end
    if (post != TABLE_ENTRIES) begin
      ext_first[post] = sector;
      return ST_OK;
    end
    return insert_run(sector, sec_t'(after - 33'd1), count);
  endfunction

  function automatic alloc_result_t predict_request(action_e act, sec_t sector, sec_t count,
                                                    sec_t last_sector);
    alloc_result_t r;
    logic [32:0]   nf;
    r.start_sector = '0;
    r.status       = ST_OK;
    case (act)
      ACT_INIT: begin
        clear_extents();
        ext_first[0] = sector;
        ext_last[0]  = last_sector;
      end
      ACT_ALLOC: begin
        if (count == 0) begin
          r.status = ST_ZERO;
        end else begin
          r.status = ST_NOFIT;
          // first fit by index
          for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
            if (ext_first[i] == 0) continue;
            if ({1'b0, ext_first[i]} + {1'b0, count} - 33'd1 <= {1'b0, ext_last[i]}) begin
              nf = {1'b0, ext_first[i]} + {1'b0, count};
              r.start_sector = ext_first[i];
              r.status       = ST_OK;
              if (nf > {1'b0, ext_last[i]}) begin
                ext_first[i] = '0;
                ext_last[i]  = '0;
              end else begin
                ext_first[i] = sec_t'(nf);
              end
              break;
            end
          end
        end
      end
      ACT_FREE: begin
        if (count == 0) r.status = ST_ZERO;
        else r.status = free_run(sector, count);
      end
      default: ;
    endcase
    return r;
  endfunction

  // request drive; valid stays up when no idle cycles are drawn
  task automatic send_request(action_e act, sec_t sector, sec_t count, sec_t last_sector);
    int unsigned gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(tb_fet_cfg_pkg::GAP_MAX);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.sector      <= sector;
    req_if.count       <= count;
    req_if.last_sector <= last_sector;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_request(act, sector, count, last_sector));
    @(negedge clk_i);
  endtask

  // directed rows
  typedef struct {
    action_e act;
    sec_t    sector;
    sec_t    count;
    sec_t    last_sector;
    bit      has_exp;
    sec_t    exp_start;
    status_e exp_status;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{ACT_ALLOC, 32'd0,        32'd1,          32'd0,          1, 32'd0,   ST_NOFIT},
    '{ACT_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 32'd0,   ST_OK},
    '{ACT_INIT,  32'd100,      32'd0,          32'd199,        1, 32'd0,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'd0,          32'd0,          1, 32'd0,   ST_ZERO},
    '{ACT_FREE,  32'd5,        32'd0,          32'd0,          1, 32'd0,   ST_ZERO},
    '{ACT_ALLOC, 32'd0,        32'd10,         32'd0,          1, 32'd100, ST_OK},
    '{ACT_ALLOC, 32'd0,        32'd200,        32'd0,          1, 32'd0,   ST_NOFIT},
    '{ACT_FREE,  32'd0,        32'd4,          32'd0,          1, 32'd0,   ST_NOFIT},
    '{ACT_FREE,  32'hFFFF_FFFF, 32'd2,         32'd0,          1, 32'd0,   ST_NOFIT},
    '{ACT_FREE,  32'd100,      32'd10,         32'd0,          0, 32'd0,   ST_OK},
    '{ACT_FREE,  32'd300,      32'd5,          32'd0,          0, 32'd0,   ST_OK},
    '{ACT_FREE,  32'd200,      32'd100,        32'd0,          0, 32'd0,   ST_OK},
    '{ACT_FREE,  32'd50,       32'd3,          32'd0,          0, 32'd0,   ST_OK},
    '{ACT_FREE,  32'd20,       32'd1,          32'd0,          0, 32'd0,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'd2,          32'd0,          0, 32'd0,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'd1,          32'd0,          0, 32'd0,   ST_OK},
    '{ACT_FREE,  32'hFFFF_FFFF, 32'd1,         32'd0,          0, 32'd0,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'hFFFF_FFFF,  32'd0,          0, 32'd0,   ST_OK},
    '{ACT_INIT,  32'd0,        32'd0,          32'd500,        1, 32'd0,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'd1,          32'd0,          1, 32'd0,   ST_NOFIT},
    '{ACT_INIT,  32'd500,      32'd0,          32'd10,         1, 32'd0,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'd1,          32'd0,          1, 32'd0,   ST_NOFIT},
    '{ACT_INIT,  32'd1,        32'd0,          32'hFFFF_FFFF,  1, 32'd0,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'hFFFF_FFFF,  32'd0,          1, 32'd1,   ST_OK},
    '{ACT_ALLOC, 32'd0,        32'd1,          32'd0,          1, 32'd0,   ST_NOFIT}
  };

  // random run: sector space kept small so neighbors and merges are common
  task automatic run_random();
    sec_t        base;
    sec_t        sec;
    sec_t        cnt;
    int unsigned sel;
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(99);
      if (n % 300 == 0 || sel < 1) begin
        base = $urandom_range(3) == 0 ? $urandom() : 32'd1 + $urandom_range(50);
        send_request(ACT_INIT, base, $urandom(), base + $urandom_range(2000));
      end else if (sel < 45) begin
        cnt = $urandom_range(9) == 0 ? $urandom() : $urandom_range(40);
        send_request(ACT_ALLOC, $urandom(), cnt, $urandom());
      end else if (sel < 97) begin
        // mostly small runs; sometimes noise over the full range
        if ($urandom_range(9) == 0) begin
          sec = $urandom();
          cnt = $urandom();
        end else begin
          sec = $urandom_range(3000);
          cnt = $urandom_range(20);
        end
        send_request(ACT_FREE, sec, cnt, $urandom());
      end else begin
        send_request(ACT_NOP, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  // stimulus
  initial begin
    directed_row_t row;
    n_errors     = 0;
    stim_done    = 1'b0;
    req_if.valid       = 1'b0;
    req_if.action      = ACT_NOP;
    req_if.sector      = '0;
    req_if.count       = '0;
    req_if.last_sector = '0;
    clear_extents();
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.act, row.sector, row.count, row.last_sector);
      if (row.has_exp) begin
        // typed-in value must agree with the predictor for the row
        if (pending_results[$].start_sector != row.exp_start ||
            pending_results[$].status != row.exp_status) begin
          $display("%0t row %0d: table exp %h/%0d, predictor %h/%0d", $time, i,
                   row.exp_start, row.exp_status, pending_results[$].start_sector,
                   pending_results[$].status);
          n_errors++;
        end
      end
    end
    run_random();
    req_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // response side stall
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(3) == 0 ? 0 : $urandom_range(tb_fet_cfg_pkg::GAP_MAX);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // result compare
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: start %h status %0d", $time,
                 rsp_if.start_sector, rsp_if.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.start_sector !== want.start_sector) begin
          $display("%0t start_sector exp %h got %h", $time, want.start_sector,
                   rsp_if.start_sector);
          n_errors++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, rsp_if.status);
          n_errors++;
        end
      end
    end
  end

  // watchdog on accepted requests and results
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    fork
      begin
        wait (stim_done && pending_results.size() == 0);
        repeat (600) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= WDOG_LIMIT);
        n_errors++;
      end
    join_any
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: free_extent_table_allocator.f
hw/rtl/fet_pkg.sv
hw/rtl/fet_req_if.sv
hw/rtl/fet_rsp_if.sv
hw/rtl/fet_ram.sv
hw/rtl/fet_ctrl.sv
hw/rtl/free_extent_table_allocator.sv
tb/tb_fet_ifs.sv
tb/tb_free_extent_table_allocator.sv
